>>> src/mbrc_pkg.sv
// ============================================================================
// mbrc_pkg: shared definitions for the masked blend with ratio correction
// Channel widths, lane count, pipeline depths and the arithmetic helpers
// used by the per-channel lanes.
// ============================================================================
package mbrc_pkg;

    localparam int CHAN_W         = 8;
    localparam int NUM_LANES      = 3;
    localparam int PIX_W          = CHAN_W * NUM_LANES;
    localparam int PROD_W         = 2 * CHAN_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = CHAN_W / BITS_PER_STAGE;
    // Multiply stage, divider stages, blend product stage.
    localparam int LANE_STAGES    = DIV_STAGES + 2;

    localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

    typedef logic [CHAN_W-1:0] t_chan;

    // One restoring division step. The partial remainder is below the divisor
    // on entry, so the shifted remainder fits CHAN_W+1 bits and the new one CHAN_W.
    // Returns {quotient bit, new remainder}.
    function automatic logic [CHAN_W:0] div_step(input t_chan rem, input logic nb,
                                                 input t_chan dv);
        logic [CHAN_W:0] t;
        logic [CHAN_W:0] diff;
        t    = {rem, nb};
        diff = t - {1'b0, dv};
        if (t >= {1'b0, dv}) begin
            return {1'b1, diff[CHAN_W-1:0]};
        end else begin
            return {1'b0, t[CHAN_W-1:0]};
        end
    endfunction

    // Exact floor(x / 255) for 16-bit x up to 255 * 255: (x + (x >> 8) + 1) >> 8.
    function automatic t_chan div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
        return s[PROD_W-1:CHAN_W];
    endfunction

endpackage

>>> src/mbrc_lane.sv
// ============================================================================
// mbrc_lane: one color channel of the blend pipeline
// Multiplies overlay by blurred base, divides by the blurred overlay two
// quotient bits per stage, saturates, then forms the two blend products.
// ============================================================================
module mbrc_lane
    import mbrc_pkg::*;
(
    input  logic  i_clk,
    input  t_chan i_base,
    input  t_chan i_base_blur,
    input  t_chan i_over,
    input  t_chan i_over_blur,
    input  t_chan i_mask,
    output t_chan o_result
);

    // Divider pipeline registers, index 0 holds the multiply stage output.
    t_chan r_rem  [0:DIV_STAGES];
    t_chan r_plo  [0:DIV_STAGES];
    t_chan r_quo  [0:DIV_STAGES];
    t_chan r_dv   [0:DIV_STAGES];
    t_chan r_base [0:DIV_STAGES];
    t_chan r_mask [0:DIV_STAGES];
    logic  r_sat  [0:DIV_STAGES];

    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] r_pa;
    logic [PROD_W-1:0] r_pc;
    logic [PROD_W:0]   w_sum;
    t_chan             w_corr;

    assign n_prod = PROD_W'(i_over) * PROD_W'(i_base_blur);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_prod[PROD_W-1:CHAN_W];
        r_plo[0]  <= n_prod[CHAN_W-1:0];
        r_quo[0]  <= '0;
        r_dv[0]   <= (i_over_blur == '0) ? t_chan'(1) : i_over_blur;
        r_base[0] <= i_base;
        r_mask[0] <= i_mask;
        r_sat[0]  <= 1'b0;
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_div
            t_chan n_rem;
            t_chan n_plo;
            t_chan n_quo;

            always_comb begin
                logic [CHAN_W:0] step;
                n_rem = r_rem[k];
                n_plo = r_plo[k];
                n_quo = r_quo[k];
                for (int j = 0; j < BITS_PER_STAGE; j++) begin
                    step  = div_step(n_rem, n_plo[CHAN_W-1], r_dv[k]);
                    n_rem = step[CHAN_W-1:0];
                    n_quo = {n_quo[CHAN_W-2:0], step[CHAN_W]};
                    n_plo = {n_plo[CHAN_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k+1]  <= n_rem;
                r_plo[k+1]  <= n_plo;
                r_quo[k+1]  <= n_quo;
                r_dv[k+1]   <= r_dv[k];
                r_base[k+1] <= r_base[k];
                r_mask[k+1] <= r_mask[k];
                if (k == 0) begin
                    // Quotient would not fit a channel: clamp later.
                    r_sat[k+1] <= (r_rem[k] >= r_dv[k]);
                end else begin
                    r_sat[k+1] <= r_sat[k];
                end
            end
        end
    endgenerate

    assign w_corr = r_sat[DIV_STAGES] ? CHAN_MAX : r_quo[DIV_STAGES];

    always_ff @(posedge i_clk) begin
        r_pa <= PROD_W'(r_base[DIV_STAGES]) * PROD_W'(CHAN_MAX - r_mask[DIV_STAGES]);
        r_pc <= PROD_W'(w_corr) * PROD_W'(r_mask[DIV_STAGES]);
    end

    // The two products sum to at most 255 * 255, so 16 bits hold the total.
    assign w_sum    = {1'b0, r_pa} + {1'b0, r_pc};
    assign o_result = div255(w_sum[PROD_W-1:0]);

endmodule

>>> src/mbrc_merge.sv
// ============================================================================
// mbrc_merge: result register for the blend lanes
// Packs the per-channel lane results into one pixel and registers it with
// its strobe.
// ============================================================================
module mbrc_merge
    import mbrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_chan [NUM_LANES-1:0]   i_lane_res,
    output logic                    o_valid,
    output logic [PIX_W-1:0]        o_pixel
);

    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Channel 0 lands in the low bits.
    always_ff @(posedge i_clk) begin
        r_pixel <= i_lane_res;
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

>>> src/masked_blend_with_ratio_correction_unit.sv
// ============================================================================
// masked_blend_with_ratio_correction_unit: masked overlay blend, gain corrected
// Blends an overlay pixel over a base pixel under an 8-bit mask after
// correcting the overlay color by the blurred base to blurred overlay ratio.
// ============================================================================
//
// Usage:
// A request carries one pixel position: base, blurred base, overlay and
// blurred overlay pixels (three 8-bit channels each, channel 0 in the low
// bits) and a mask level. It is taken at a rising edge where start is high
// and busy is low. Busy never rises, so a new request may be issued every
// cycle and the unit sustains one pixel per clock.
// Each channel runs in its own lane: an 8x8 multiply, a four-stage restoring
// divider retiring two quotient bits per stage, and a blend product stage;
// a merge register joins the three lanes. A request's data passes the
// multiply register, the divider stage registers, the blend product
// register and the merge register, and is then shown on o_blended_pixel
// with o_valid high. Results leave in request order.
// The receiver cannot stall; every result is shown for exactly one cycle.
// A synchronous reset clears the valid pipeline, dropping requests in flight.
//
module masked_blend_with_ratio_correction_unit
    import mbrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [PIX_W-1:0] i_base_pixel,
    input  logic [PIX_W-1:0] i_base_blur_pixel,
    input  logic [PIX_W-1:0] i_over_pixel,
    input  logic [PIX_W-1:0] i_over_blur_pixel,
    input  logic [CHAN_W-1:0] i_mask_level,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_blended_pixel
);

    // The pipeline never holds back, so requests are always accepted.
    assign busy = 1'b0;

    // Valid bits travel alongside the lane data registers.
    logic [LANE_STAGES-1:0] r_vld;
    logic                   w_accept;

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LANE_STAGES-2:0], w_accept};
        end
    end

    t_chan [NUM_LANES-1:0] w_lane_res;

    genvar c;
    generate
        for (c = 0; c < NUM_LANES; c++) begin : g_lane
            mbrc_lane u_lane (
                .i_clk       (i_clk),
                .i_base      (i_base_pixel[c*CHAN_W +: CHAN_W]),
                .i_base_blur (i_base_blur_pixel[c*CHAN_W +: CHAN_W]),
                .i_over      (i_over_pixel[c*CHAN_W +: CHAN_W]),
                .i_over_blur (i_over_blur_pixel[c*CHAN_W +: CHAN_W]),
                .i_mask      (i_mask_level),
                .o_result    (w_lane_res[c])
            );
        end
    endgenerate

    mbrc_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vld[LANE_STAGES-1]),
        .i_lane_res (w_lane_res),
        .o_valid    (o_valid),
        .o_pixel    (o_blended_pixel)
    );

endmodule

>>> src/mbrc_checker.sv
// ============================================================================
// mbrc_checker: port-level checks for the masked blend unit
// Watches the request and result ports and checks timing and the mask and
// gain special cases over the fixed pipeline latency.
// ============================================================================
module mbrc_checker
    import mbrc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [PIX_W-1:0]  i_base_pixel,
    input logic [PIX_W-1:0]  i_base_blur_pixel,
    input logic [PIX_W-1:0]  i_over_pixel,
    input logic [PIX_W-1:0]  i_over_blur_pixel,
    input logic [CHAN_W-1:0] i_mask_level,
    input logic              o_valid,
    input logic [PIX_W-1:0]  o_blended_pixel
);

    localparam int LAT = LANE_STAGES + 1;

    // All ones once a one has shifted through every bit since reset.
    logic [LAT-1:0] r_run;
    logic           w_settled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else begin
            r_run <= {r_run[LAT-2:0], 1'b1};
        end
    end

    assign w_settled = &r_run;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised although the pipeline never stalls");

    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_settled |-> (o_valid == $past(start && !busy, LAT)))
        else $error("result strobe does not follow its request by the latency");

    a_mask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_settled && o_valid && $past(i_mask_level == '0, LAT))
            |-> (o_blended_pixel == $past(i_base_pixel, LAT)))
        else $error("zero mask did not pass the base pixel through");

    a_unit_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_settled && o_valid
            && $past(i_mask_level == CHAN_MAX, LAT)
            && $past(i_base_blur_pixel == i_over_blur_pixel, LAT)
            && $past(|i_over_blur_pixel[7:0], LAT)
            && $past(|i_over_blur_pixel[15:8], LAT)
            && $past(|i_over_blur_pixel[23:16], LAT))
            |-> (o_blended_pixel == $past(i_over_pixel, LAT)))
        else $error("full mask with unit gain did not return the overlay");

endmodule

bind masked_blend_with_ratio_correction_unit mbrc_checker u_mbrc_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench for masked_blend_with_ratio_correction_unit
// Each request carries one pixel position. The testbench sends a short table
// of directed requests and then a long random stream, with random gaps from
// the sender. It predicts each blended pixel, or takes it from the table
// where the row gives it, and checks the results in request order.
// ============================================================================
module tb
    import mbrc_pkg::*;
();

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    // Idle time after the last result is back, so that a stray late result
    // is still seen.
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1900;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1100;
    localparam int NUM_DIRECTED = 15;

    typedef logic [PIX_W-1:0] t_pixel;

    // One row of stimulus. Where the result can be read off at a glance,
    // has_known is set and known holds it; otherwise the predictor decides.
    typedef struct packed {
        t_pixel base;
        t_pixel base_blur;
        t_pixel over;
        t_pixel over_blur;
        t_chan  mask;
        logic   has_known;
        t_pixel known;
    } t_blend_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_pixel i_base_pixel = '0;
    t_pixel i_base_blur_pixel = '0;
    t_pixel i_over_pixel = '0;
    t_pixel i_over_blur_pixel = '0;
    t_chan  i_mask_level = '0;
    logic   o_valid;
    t_pixel o_blended_pixel;

    // Typed expectation that travels alongside the request.
    logic   req_has_known = 1'b0;
    t_pixel req_known = '0;

    t_pixel     pending_pixels[$];
    int         mismatches = 0;
    t_blend_row directed_rows [NUM_DIRECTED];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    masked_blend_with_ratio_correction_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_base_pixel     (i_base_pixel),
        .i_base_blur_pixel(i_base_blur_pixel),
        .i_over_pixel     (i_over_pixel),
        .i_over_blur_pixel(i_over_blur_pixel),
        .i_mask_level     (i_mask_level),
        .o_valid          (o_valid),
        .o_blended_pixel  (o_blended_pixel)
    );

    // Per channel: gain correct the overlay by blurred base over blurred
    // overlay (a zero divisor counts as one), clip at full scale, then mix
    // with the base under the mask.
    function automatic t_pixel blend_pixel(input t_pixel b, input t_pixel s,
                                           input t_pixel o, input t_pixel d,
                                           input t_chan m);
        t_pixel      px;
        int unsigned full;
        int unsigned mc;
        int unsigned bc;
        int unsigned sc;
        int unsigned oc;
        int unsigned dc;
        int unsigned gain;
        int unsigned mix;
        px   = '0;
        full = 32'(CHAN_MAX);
        mc   = 32'(m);
        for (int c = 0; c < NUM_LANES; c++) begin
            bc = 32'(b[c*CHAN_W +: CHAN_W]);
            sc = 32'(s[c*CHAN_W +: CHAN_W]);
            oc = 32'(o[c*CHAN_W +: CHAN_W]);
            dc = 32'(d[c*CHAN_W +: CHAN_W]);
            if (dc == 0) begin
                dc = 1;
            end
            gain = (oc * sc) / dc;
            if (gain > full) begin
                gain = full;
            end
            mix = (bc * (full - mc) + gain * mc) / full;
            px[c*CHAN_W +: CHAN_W] = t_chan'(mix);
        end
        return px;
    endfunction

    // Channel values lean toward the edges of the range and small divisors.
    function automatic t_chan rand_chan();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CHAN_MAX;
            2: return t_chan'($urandom_range(1, 8));
            default: return t_chan'($urandom);
        endcase
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        for (int c = 0; c < NUM_LANES; c++) begin
            px[c*CHAN_W +: CHAN_W] = rand_chan();
        end
        return px;
    endfunction

    function automatic t_blend_row rand_row();
        t_blend_row row;
        row = '0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
                row.base      = t_pixel'($urandom);
                row.base_blur = t_pixel'($urandom);
                row.over      = t_pixel'($urandom);
                row.over_blur = t_pixel'($urandom);
            end
            5, 6, 7, 8, 9, 10, 11: begin
                row.base      = rand_pixel();
                row.base_blur = rand_pixel();
                row.over      = rand_pixel();
                row.over_blur = rand_pixel();
            end
            default: begin
                // Blurred overlay close to blurred base keeps the gain near
                // one, so the corrected value mostly stays below the clip.
                row.base      = t_pixel'($urandom);
                row.base_blur = t_pixel'($urandom);
                row.over      = t_pixel'($urandom);
                row.over_blur = row.base_blur ^ (t_pixel'($urandom) & 24'h0F0F0F);
            end
        endcase
        case ($urandom_range(0, 9))
            0: row.mask = '0;
            1: row.mask = CHAN_MAX;
            default: row.mask = t_chan'($urandom);
        endcase
        return row;
    endfunction

    // Puts one request on the ports and holds it until it is taken. Start is
    // left high so that back-to-back requests need no extra assignment.
    task automatic issue_request(input t_blend_row row);
        start             <= 1'b1;
        i_base_pixel      <= row.base;
        i_base_blur_pixel <= row.base_blur;
        i_over_pixel      <= row.over;
        i_over_blur_pixel <= row.over_blur;
        i_mask_level      <= row.mask;
        req_has_known     <= row.has_known;
        req_known         <= row.known;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // The sender stays quiet in about one cycle of ten.
    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result checker and request capture. Both sample the values that stood
    // before the edge, so the order of processes within the step is moot.
    always @(posedge i_clk) begin : check_results
        t_pixel want;
        t_pixel next_px;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_pixels.size() == 0) begin
                    $error("blended_pixel: expected none, actual %h", o_blended_pixel);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_blended_pixel !== want) begin
                        $error("blended_pixel: expected %h, actual %h", want,
                               o_blended_pixel);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                if (req_has_known) begin
                    next_px = req_known;
                end else begin
                    next_px = blend_pixel(i_base_pixel, i_base_blur_pixel,
                                          i_over_pixel, i_over_blur_pixel,
                                          i_mask_level);
                end
                pending_pixels = {pending_pixels, next_px};
            end
        end
    end

    initial begin
        // Columns: base, blurred base, overlay, blurred overlay, mask,
        // known-result flag, known result.
        directed_rows = '{
            // Everything zero.
            '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 8'h00, 1'b1, 24'h000000},
            // Everything at full scale: gain of one, full mask.
            '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1, 24'hFFFFFF},
            // Zero mask passes the base through untouched.
            '{24'hA5C3E7, 24'hFFFFFF, 24'hFFFFFF, 24'h010101, 8'h00, 1'b1, 24'hA5C3E7},
            // Zero blurred overlay with a huge product clips to full scale.
            '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 8'hFF, 1'b1, 24'hFFFFFF},
            // Zero blurred overlay divides by one: corrected value is O*S.
            '{24'hFFFFFF, 24'h070503, 24'h010101, 24'h000000, 8'hFF, 1'b1, 24'h070503},
            // Equal blurs leave the overlay as it is under a full mask.
            '{24'h000000, 24'h808080, 24'h123456, 24'h808080, 8'hFF, 1'b1, 24'h123456},
            // Black overlay under a full mask.
            '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h404040, 8'hFF, 1'b1, 24'h000000},
            // Clipping with a nonzero divisor.
            '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 8'hFF, 1'b1, 24'hFFFFFF},
            // The rest go through the predictor.
            '{24'h804020, 24'hFF8010, 24'h80FF40, 24'h40C0FF, 8'h80, 1'b0, 24'h000000},
            '{24'hFFFFFF, 24'h102030, 24'h405060, 24'h203040, 8'h01, 1'b0, 24'h000000},
            '{24'h000000, 24'h102030, 24'h405060, 24'h203040, 8'hFE, 1'b0, 24'h000000},
            '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 8'hAA, 1'b0, 24'h000000},
            '{24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 8'h55, 1'b0, 24'h000000},
            '{24'hFF00FF, 24'h00FF00, 24'hFF00FF, 24'h00FF01, 8'h7F, 1'b0, 24'h000000},
            '{24'h01FE80, 24'hFE0180, 24'h80FE01, 24'h0180FE, 8'hC3, 1'b0, 24'h000000}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            maybe_idle(1'b1);
            issue_request(directed_rows[i]);
        end
        wait_for_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                wait_for_results();
            end
            maybe_idle(i < QUIET_FIRST || i >= QUIET_LAST);
            issue_request(rand_row());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
